### hw/rtl/crc8_dfr_pkg.sv
package crc8_dfr_pkg;

    // Counter width; outputs show the low 32 bits
    localparam int COUNT_WIDTH = 32;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_VALUE    = 2'd0;
    localparam logic [1:0] CFG_ACCEPTED_TYPE = 2'd1;
    localparam logic [1:0] CFG_MAX_LENGTH    = 2'd2;

    // Verdict codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TOO_LONG = 3'd1;
    localparam logic [2:0] ST_CRC_BAD  = 3'd2;
    localparam logic [2:0] ST_TYPE_BAD = 3'd3;
    localparam logic [2:0] ST_OVERRUN  = 3'd4;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_TYPE,
        PH_PAYLOAD,
        PH_CRC
    } phase_t;

    typedef enum logic [1:0] {
        TLV_ID,
        TLV_LEN,
        TLV_VALUE
    } tlv_phase_t;

    // One byte of CRC-8 (MSB first, no reflection)
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_TOP) != 8'h00)
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Saturating increment
    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        if (v == {COUNT_WIDTH{1'b1}})
        begin
            return v;
        end
        return v + COUNT_WIDTH'(1);
    endfunction

endpackage

### hw/rtl/crc8_packet_deframer_tlv_check_unit.sv
// Serial packet deframer with CRC-8 and TLV overrun check.
//
// Input channel: in_valid / in_stall carry one received byte (rx_byte) per
// transfer. Output channel: out_valid / out_stall carry either a payload byte
// with its offset (kind 0) or a frame verdict with saturating good and bad
// counts (kind 1). Sync, type and in-range length bytes give no output.
// Configuration: cfg_write with cfg_index and cfg_data writes sync value,
// accepted type or max length; write only while the block is idle.
//
// A result is in the output register the cycle after its byte transfer; one
// byte per cycle is taken while out_stall holds no result. The per-byte CRC-8
// update and framing checks sit between the frame state and the output
// register. While a result is held by out_stall, in_stall is raised; once the
// output register is taken, a new byte transfers in the same cycle.
// Reset (rst_n low) hunts for sync, clears counters, empties the output
// register and restores the register defaults (sync 0xAA, type 1, max 1024).
module crc8_packet_deframer_tlv_check_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  data,
    output logic [15:0] offset,
    output logic [2:0]  status,
    output logic [15:0] frame_length,
    output logic [31:0] good_count,
    output logic [31:0] bad_count
);

    localparam int CW = crc8_dfr_pkg::COUNT_WIDTH;

    // Configuration
    logic [7:0]  sync_value_reg;
    logic [7:0]  accepted_type_reg;
    logic [15:0] max_length_reg;

    // Frame state
    crc8_dfr_pkg::phase_t     phase_reg, phase_next;
    crc8_dfr_pkg::tlv_phase_t tlv_phase_reg, tlv_phase_next;
    logic [15:0] decl_len_reg, decl_len_next;
    logic [15:0] byte_pos_reg, byte_pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  frame_type_reg, frame_type_next;
    logic [7:0]  tlv_left_reg, tlv_left_next;
    logic [CW-1:0] good_total_reg, good_total_next;
    logic [CW-1:0] bad_total_reg, bad_total_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg;
    logic [7:0]  data_reg;
    logic [15:0] offset_reg;
    logic [2:0]  status_reg;
    logic [15:0] frame_length_reg;
    logic [31:0] good_count_reg;
    logic [31:0] bad_count_reg;

    // Result of the current byte
    logic        res_valid;
    logic        res_kind;
    logic [2:0]  res_status;

    logic        accept;
    logic [15:0] len_full;
    logic [16:0] pos_inc;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign len_full = {rx_byte, decl_len_reg[7:0]};
    assign pos_inc  = {1'b0, byte_pos_reg} + 17'd1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_value_reg    <= 8'd170;
            accepted_type_reg <= 8'd1;
            max_length_reg    <= 16'd1024;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                crc8_dfr_pkg::CFG_SYNC_VALUE:    sync_value_reg    <= cfg_data[7:0];
                crc8_dfr_pkg::CFG_ACCEPTED_TYPE: accepted_type_reg <= cfg_data[7:0];
                crc8_dfr_pkg::CFG_MAX_LENGTH:    max_length_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the frame phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            crc8_dfr_pkg::PH_HUNT:
            begin
                if (rx_byte == sync_value_reg)
                begin
                    phase_next = crc8_dfr_pkg::PH_LEN_LO;
                end
            end
            crc8_dfr_pkg::PH_LEN_LO:
            begin
                phase_next = crc8_dfr_pkg::PH_LEN_HI;
            end
            crc8_dfr_pkg::PH_LEN_HI:
            begin
                phase_next = (len_full > max_length_reg) ? crc8_dfr_pkg::PH_HUNT
                                                         : crc8_dfr_pkg::PH_TYPE;
            end
            crc8_dfr_pkg::PH_TYPE:
            begin
                phase_next = (decl_len_reg == 16'd0) ? crc8_dfr_pkg::PH_CRC
                                                     : crc8_dfr_pkg::PH_PAYLOAD;
            end
            crc8_dfr_pkg::PH_PAYLOAD:
            begin
                if (pos_inc >= {1'b0, decl_len_reg})
                begin
                    phase_next = crc8_dfr_pkg::PH_CRC;
                end
            end
            crc8_dfr_pkg::PH_CRC:
            begin
                phase_next = crc8_dfr_pkg::PH_HUNT;
            end
            default:
            begin
                phase_next = crc8_dfr_pkg::PH_HUNT;
            end
        endcase
    end

    // Update frame data, CRC, TLV tracking, counters and form the result
    always_comb
    begin
        decl_len_next   = decl_len_reg;
        byte_pos_next   = byte_pos_reg;
        crc_next        = crc_reg;
        frame_type_next = frame_type_reg;
        tlv_phase_next  = tlv_phase_reg;
        tlv_left_next   = tlv_left_reg;
        good_total_next = good_total_reg;
        bad_total_next  = bad_total_reg;
        res_valid       = 1'b0;
        res_kind        = crc8_dfr_pkg::KIND_PAYLOAD;
        res_status      = crc8_dfr_pkg::ST_OK;
        case (phase_reg)
            crc8_dfr_pkg::PH_HUNT:
            begin
                if (rx_byte == sync_value_reg)
                begin
                    crc_next = 8'h00;
                end
            end
            crc8_dfr_pkg::PH_LEN_LO:
            begin
                decl_len_next = {8'h00, rx_byte};
            end
            crc8_dfr_pkg::PH_LEN_HI:
            begin
                decl_len_next = len_full;
                if (len_full > max_length_reg)
                begin
                    bad_total_next = crc8_dfr_pkg::sat_inc(bad_total_reg);
                    res_valid      = 1'b1;
                    res_kind       = crc8_dfr_pkg::KIND_VERDICT;
                    res_status     = crc8_dfr_pkg::ST_TOO_LONG;
                end
            end
            crc8_dfr_pkg::PH_TYPE:
            begin
                frame_type_next = rx_byte;
                crc_next        = crc8_dfr_pkg::crc8_update(8'h00, rx_byte);
                byte_pos_next   = 16'd0;
                tlv_phase_next  = crc8_dfr_pkg::TLV_ID;
                tlv_left_next   = 8'd0;
            end
            crc8_dfr_pkg::PH_PAYLOAD:
            begin
                res_valid     = 1'b1;
                crc_next      = crc8_dfr_pkg::crc8_update(crc_reg, rx_byte);
                byte_pos_next = pos_inc[15:0];
                case (tlv_phase_reg)
                    crc8_dfr_pkg::TLV_ID:
                    begin
                        tlv_phase_next = crc8_dfr_pkg::TLV_LEN;
                    end
                    crc8_dfr_pkg::TLV_LEN:
                    begin
                        tlv_left_next  = rx_byte;
                        tlv_phase_next = (rx_byte == 8'd0) ? crc8_dfr_pkg::TLV_ID
                                                           : crc8_dfr_pkg::TLV_VALUE;
                    end
                    default:
                    begin
                        tlv_left_next = tlv_left_reg - 8'd1;
                        if (tlv_left_reg == 8'd1)
                        begin
                            tlv_phase_next = crc8_dfr_pkg::TLV_ID;
                        end
                    end
                endcase
            end
            crc8_dfr_pkg::PH_CRC:
            begin
                res_valid = 1'b1;
                res_kind  = crc8_dfr_pkg::KIND_VERDICT;
                if (rx_byte != crc_reg)
                begin
                    res_status     = crc8_dfr_pkg::ST_CRC_BAD;
                    bad_total_next = crc8_dfr_pkg::sat_inc(bad_total_reg);
                end
                else if (frame_type_reg != accepted_type_reg)
                begin
                    res_status     = crc8_dfr_pkg::ST_TYPE_BAD;
                    bad_total_next = crc8_dfr_pkg::sat_inc(bad_total_reg);
                end
                else
                begin
                    good_total_next = crc8_dfr_pkg::sat_inc(good_total_reg);
                    if (tlv_phase_reg == crc8_dfr_pkg::TLV_VALUE)
                    begin
                        res_status     = crc8_dfr_pkg::ST_OVERRUN;
                        bad_total_next = crc8_dfr_pkg::sat_inc(bad_total_reg);
                    end
                end
            end
            default: ;
        endcase
    end

    // Hold frame state; update on each byte transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= crc8_dfr_pkg::PH_HUNT;
            tlv_phase_reg  <= crc8_dfr_pkg::TLV_ID;
            decl_len_reg   <= 16'd0;
            byte_pos_reg   <= 16'd0;
            crc_reg        <= 8'h00;
            frame_type_reg <= 8'h00;
            tlv_left_reg   <= 8'd0;
            good_total_reg <= '0;
            bad_total_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            tlv_phase_reg  <= tlv_phase_next;
            decl_len_reg   <= decl_len_next;
            byte_pos_reg   <= byte_pos_next;
            crc_reg        <= crc_next;
            frame_type_reg <= frame_type_next;
            tlv_left_reg   <= tlv_left_next;
            good_total_reg <= good_total_next;
            bad_total_reg  <= bad_total_next;
        end
    end

    // Output valid: load on transfer, drop once taken, hold while stalled
    always_comb
    begin
        if (accept)
        begin
            out_valid_next = res_valid;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            kind_reg         <= res_kind;
            data_reg         <= (res_kind == crc8_dfr_pkg::KIND_PAYLOAD) ? rx_byte : 8'h00;
            offset_reg       <= (res_kind == crc8_dfr_pkg::KIND_PAYLOAD) ? byte_pos_reg
                                                                         : 16'd0;
            status_reg       <= res_status;
            frame_length_reg <= decl_len_next;
            good_count_reg   <= 32'(good_total_next);
            bad_count_reg    <= 32'(bad_total_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign data         = data_reg;
    assign offset       = offset_reg;
    assign status       = status_reg;
    assign frame_length = frame_length_reg;
    assign good_count   = good_count_reg;
    assign bad_count    = bad_count_reg;

endmodule
